>>> rtl/dfcc_pkg.sv
// ----------------------------------------------------------------------------
// dfcc_pkg
// Shared types, codes and the CRC-16/CCITT-FALSE byte update for the codec.
// ----------------------------------------------------------------------------
package dfcc_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [7:0]  SEND_DIR = 8'h7F;
  localparam logic [7:0]  RECV_DIR = 8'hFF;
  localparam logic [1:0]  LEN_HI_MASK = 2'h3;

  localparam int QUEUE_DEPTH = 4;
  localparam int MAX_SLOTS   = 4;

  typedef enum logic [1:0] {
    KIND_LINE    = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_STATUS  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_DIR   = 2'd1,
    ST_CRC_ERR   = 2'd2,
    ST_TRUNCATED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_LEN_HI  = 3'd1,
    PH_LEN_LO  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CRC_HI  = 3'd4,
    PH_CRC_LO  = 3'd5,
    PH_DRAIN   = 3'd6
  } phase_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] val;
    status_t    status;
  } slot_t;

  typedef struct packed {
    logic [2:0]                 cnt;
    slot_t [MAX_SLOTS-1:0]      slot;
  } entry_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/download_frame_crc_codec_top.sv
// ----------------------------------------------------------------------------
// download_frame_crc_codec_top
// Byte-serial framing codec with CRC-16/CCITT-FALSE: send framing and
// receive checking, front classifier feeding a result queue and emitter.
// ----------------------------------------------------------------------------
// channel | dir | tdata                                  | tuser | tlast
// in_     | in  | [7:0] data_byte, [17:8] deliver_limit  | cmd   | last_byte
// out_    | out | [7:0] out_byte, [9:8] status           | kind  | end_of_run
//
// One input word is taken per cycle while the queue has room; the CRC update
// is combinational in the front. Each input word yields 0 to 4 result words,
// one per cycle at the output while out_tready is high, so the output port sets the sustained rate.
// Synchronous active-low reset clears framing state and the queue.
// Either side may stall; the queue of QUEUE_DEPTH entries decouples them.
// ----------------------------------------------------------------------------
module download_frame_crc_codec_top #(
  parameter int QUEUE_DEPTH = dfcc_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] data_byte, [17:8] deliver_limit
  input  logic        in_tuser,   // [0] cmd
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [9:8] status
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast
);

  logic             acc;
  logic             push;
  logic             pop;
  logic             empty;
  logic             full;
  dfcc_pkg::entry_t entry;
  dfcc_pkg::entry_t head;

  assign in_tready = !full;
  assign acc       = in_tvalid && in_tready;

  dfcc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .acc           (acc),
    .cmd           (in_tuser),
    .data_byte     (in_tdata[7:0]),
    .last_byte     (in_tlast),
    .deliver_limit (in_tdata[17:8]),
    .push          (push),
    .entry         (entry)
  );

  dfcc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (entry),
    .pop        (pop),
    .head       (head),
    .empty      (empty),
    .full       (full)
  );

  dfcc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

>>> rtl/dfcc_front.sv
// ----------------------------------------------------------------------------
// dfcc_front
// Accepts words, tracks send and receive framing, and builds one queue entry
// listing every result word the input word causes.
// ----------------------------------------------------------------------------
module dfcc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  logic              cmd,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  input  logic [9:0]        deliver_limit,
  output logic              push,
  output dfcc_pkg::entry_t  entry
);

  logic              send_active_r, send_active_nxt;
  logic [15:0]       send_crc_r, send_crc_nxt;
  dfcc_pkg::phase_t  phase_r, phase_nxt;
  logic [15:0]       recv_crc_r, recv_crc_nxt;
  logic [10:0]       recv_count_r, recv_count_nxt;
  logic [9:0]        payload_len_r, payload_len_nxt;
  logic [7:0]        crc_high_r, crc_high_nxt;
  logic [9:0]        limit_r, limit_nxt;

  logic [15:0]       send_base;
  logic [15:0]       send_upd;
  logic [15:0]       recv_upd;
  logic [10:0]       count_inc;
  logic [15:0]       crc_got;
  logic              pay_emit;
  logic              st_emit;
  dfcc_pkg::status_t st_code;
  dfcc_pkg::slot_t   pay_slot;
  dfcc_pkg::slot_t   st_slot;

  assign send_base = send_active_r ? send_crc_r : dfcc_pkg::CRC_INIT;
  assign send_upd  = dfcc_pkg::crc_byte(send_base, data_byte);
  assign recv_upd  = dfcc_pkg::crc_byte(recv_crc_r, data_byte);
  assign count_inc = recv_count_r + 11'd1;
  assign crc_got   = {crc_high_r, data_byte};

  // next state
  always_comb begin
    send_active_nxt = send_active_r;
    send_crc_nxt    = send_crc_r;
    phase_nxt       = phase_r;
    recv_crc_nxt    = recv_crc_r;
    recv_count_nxt  = recv_count_r;
    payload_len_nxt = payload_len_r;
    crc_high_nxt    = crc_high_r;
    limit_nxt       = limit_r;
    if (acc && !cmd) begin
      send_active_nxt = !last_byte;
      send_crc_nxt    = last_byte ? dfcc_pkg::CRC_INIT : send_upd;
    end else if (acc && cmd) begin
      case (phase_r)
        dfcc_pkg::PH_IDLE: begin
          limit_nxt       = deliver_limit;
          recv_crc_nxt    = dfcc_pkg::CRC_INIT;
          recv_count_nxt  = '0;
          payload_len_nxt = '0;
          crc_high_nxt    = '0;
          if (data_byte != dfcc_pkg::RECV_DIR) begin
            phase_nxt = last_byte ? dfcc_pkg::PH_IDLE : dfcc_pkg::PH_DRAIN;
          end else begin
            phase_nxt = last_byte ? dfcc_pkg::PH_IDLE : dfcc_pkg::PH_LEN_HI;
          end
        end
        dfcc_pkg::PH_LEN_HI: begin
          recv_crc_nxt    = recv_upd;
          payload_len_nxt = {data_byte[1:0] & dfcc_pkg::LEN_HI_MASK, 8'h00};
          phase_nxt       = dfcc_pkg::PH_LEN_LO;
        end
        dfcc_pkg::PH_LEN_LO: begin
          recv_crc_nxt    = recv_upd;
          payload_len_nxt = payload_len_r | {2'b00, data_byte};
          phase_nxt = ((payload_len_r | {2'b00, data_byte}) != 10'd0) ?
                      dfcc_pkg::PH_PAYLOAD : dfcc_pkg::PH_CRC_HI;
        end
        dfcc_pkg::PH_PAYLOAD: begin
          recv_crc_nxt   = recv_upd;
          recv_count_nxt = count_inc;
          if (count_inc >= {1'b0, payload_len_r}) begin
            phase_nxt = dfcc_pkg::PH_CRC_HI;
          end
        end
        dfcc_pkg::PH_CRC_HI: begin
          crc_high_nxt = data_byte;
          phase_nxt    = dfcc_pkg::PH_CRC_LO;
        end
        dfcc_pkg::PH_CRC_LO: begin
          phase_nxt = last_byte ? dfcc_pkg::PH_IDLE : dfcc_pkg::PH_DRAIN;
        end
        default: begin
          if (last_byte) begin
            phase_nxt = dfcc_pkg::PH_IDLE;
          end
        end
      endcase
      if (last_byte && (phase_r == dfcc_pkg::PH_LEN_HI || phase_r == dfcc_pkg::PH_LEN_LO ||
                        phase_r == dfcc_pkg::PH_PAYLOAD || phase_r == dfcc_pkg::PH_CRC_HI)) begin
        phase_nxt = dfcc_pkg::PH_IDLE;
      end
    end
  end

  // outputs
  always_comb begin
    pay_emit = 1'b0;
    st_emit  = 1'b0;
    st_code  = dfcc_pkg::ST_OK;
    case (phase_r)
      dfcc_pkg::PH_IDLE: begin
        if (data_byte != dfcc_pkg::RECV_DIR) begin
          st_emit = 1'b1;
          st_code = dfcc_pkg::ST_BAD_DIR;
        end else if (last_byte) begin
          st_emit = 1'b1;
          st_code = dfcc_pkg::ST_TRUNCATED;
        end
      end
      dfcc_pkg::PH_CRC_LO: begin
        st_emit = 1'b1;
        st_code = (crc_got == recv_crc_r) ? dfcc_pkg::ST_OK : dfcc_pkg::ST_CRC_ERR;
      end
      dfcc_pkg::PH_DRAIN: begin
        st_emit = 1'b0;
      end
      default: begin
        pay_emit = (phase_r == dfcc_pkg::PH_PAYLOAD) && (recv_count_r < {1'b0, limit_r});
        if (last_byte) begin
          st_emit = 1'b1;
          st_code = dfcc_pkg::ST_TRUNCATED;
        end
      end
    endcase

    pay_slot = '{kind: dfcc_pkg::KIND_PAYLOAD, val: data_byte, status: dfcc_pkg::ST_OK};
    st_slot  = '{kind: dfcc_pkg::KIND_STATUS, val: 8'h00, status: st_code};
    entry    = '0;

    if (!cmd) begin
      if (!send_active_r) begin
        entry.slot[0] = '{kind: dfcc_pkg::KIND_LINE, val: dfcc_pkg::SEND_DIR,
                          status: dfcc_pkg::ST_OK};
        entry.slot[1] = '{kind: dfcc_pkg::KIND_LINE, val: data_byte, status: dfcc_pkg::ST_OK};
        entry.slot[2] = '{kind: dfcc_pkg::KIND_LINE, val: send_upd[15:8],
                          status: dfcc_pkg::ST_OK};
        entry.slot[3] = '{kind: dfcc_pkg::KIND_LINE, val: send_upd[7:0], status: dfcc_pkg::ST_OK};
        entry.cnt     = last_byte ? 3'd4 : 3'd2;
      end else begin
        entry.slot[0] = '{kind: dfcc_pkg::KIND_LINE, val: data_byte, status: dfcc_pkg::ST_OK};
        entry.slot[1] = '{kind: dfcc_pkg::KIND_LINE, val: send_upd[15:8],
                          status: dfcc_pkg::ST_OK};
        entry.slot[2] = '{kind: dfcc_pkg::KIND_LINE, val: send_upd[7:0], status: dfcc_pkg::ST_OK};
        entry.cnt     = last_byte ? 3'd3 : 3'd1;
      end
    end else begin
      entry.slot[0] = pay_emit ? pay_slot : st_slot;
      entry.slot[1] = st_slot;
      entry.cnt     = {2'b00, pay_emit} + {2'b00, st_emit};
    end

    push = acc && (entry.cnt != 3'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      send_active_r <= 1'b0;
      send_crc_r    <= dfcc_pkg::CRC_INIT;
      phase_r       <= dfcc_pkg::PH_IDLE;
      recv_crc_r    <= dfcc_pkg::CRC_INIT;
      recv_count_r  <= '0;
      payload_len_r <= '0;
      crc_high_r    <= '0;
      limit_r       <= '0;
    end else begin
      send_active_r <= send_active_nxt;
      send_crc_r    <= send_crc_nxt;
      phase_r       <= phase_nxt;
      recv_crc_r    <= recv_crc_nxt;
      recv_count_r  <= recv_count_nxt;
      payload_len_r <= payload_len_nxt;
      crc_high_r    <= crc_high_nxt;
      limit_r       <= limit_nxt;
    end
  end

endmodule

>>> rtl/dfcc_queue.sv
// ----------------------------------------------------------------------------
// dfcc_queue
// Short FIFO of result entries between front and back.
// ----------------------------------------------------------------------------
module dfcc_queue #(
  parameter int DEPTH = dfcc_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  dfcc_pkg::entry_t  push_entry,
  input  logic              pop,
  output dfcc_pkg::entry_t  head,
  output logic              empty,
  output logic              full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  dfcc_pkg::entry_t mem [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign empty = (count_r == CW'(0));
  assign full  = (count_r == CW'(DEPTH));
  assign head  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> rtl/dfcc_back.sv
// ----------------------------------------------------------------------------
// dfcc_back
// Takes entries from the queue and hands their result words out one by one.
// ----------------------------------------------------------------------------
module dfcc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  dfcc_pkg::entry_t  head,
  input  logic              empty,
  output logic              pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata,
  output logic [1:0]        out_tuser,
  output logic              out_tlast
);

  dfcc_pkg::entry_t cur_r, cur_nxt;
  logic             valid_r, valid_nxt;
  logic [1:0]       idx_r, idx_nxt;
  logic             last_slot;
  logic             take;
  dfcc_pkg::slot_t  sel;

  assign last_slot = ({1'b0, idx_r} == (cur_r.cnt - 3'd1));
  assign take      = valid_r && out_tready;
  assign pop       = !empty && (!valid_r || (take && last_slot));
  assign sel       = cur_r.slot[idx_r];

  assign out_tvalid = valid_r;
  assign out_tdata  = {6'b000000, sel.status, sel.val};
  assign out_tuser  = sel.kind;
  assign out_tlast  = last_slot;

  always_comb begin
    cur_nxt   = cur_r;
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (pop) begin
      cur_nxt   = head;
      valid_nxt = 1'b1;
      idx_nxt   = '0;
    end else if (take && last_slot) begin
      valid_nxt = 1'b0;
    end else if (take) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> ({1'b0, idx_r} < cur_r.cnt))
    else $error("slot index beyond entry count");

  a_pop_only_free: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (!valid_r || (out_tready && last_slot)))
    else $error("entry loaded over unfinished one");

  a_advance_on_take: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !out_tready) |=> (valid_r && $stable(idx_r)))
    else $error("slot moved without a take");

endmodule

>>> test/tb_download_frame_crc_codec_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_download_frame_crc_codec_top
// Self-checking bench for the download frame CRC codec. Send frames, receive
// frames (clean, corrupted CRC, cut short, trailing bytes, bad direction) and
// line noise are interleaved on the input stream. A bit-accurate predictor
// runs on every accepted word, and each output word is checked in order.
// Both stream sides idle at random. One long output stall backs up the block,
// and one input pause waits until the output has drained.
// ----------------------------------------------------------------------------
module tb_download_frame_crc_codec_top;

  localparam int HALF_PERIOD    = 10;
  localparam int RESET_CYCLES   = 8;
  localparam int RANDOM_ITEMS   = 260;
  localparam int SQUEEZE_CYCLES = 300;
  localparam int TAIL_CYCLES    = 32;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int REPORT_CAP     = 40;

  localparam logic CMD_SEND = 1'b0;
  localparam logic CMD_RECV = 1'b1;

  typedef enum int {FR_CLEAN, FR_BAD_CRC, FR_CUT, FR_TRAIL, FR_BAD_DIR} frame_flaw_t;

  typedef struct {
    logic       cmd;
    logic [7:0] data;
    logic       last;
    logic [9:0] limit;
  } link_item_t;

  typedef struct {
    dfcc_pkg::kind_t   kind;
    logic [7:0]        val;
    dfcc_pkg::status_t status;
    logic              eor;
  } codec_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  link_item_t  feed_q[$];
  link_item_t  tx_stage[$];
  link_item_t  rx_stage[$];
  codec_word_t awaited_q[$];
  link_item_t  cur_item;

  logic             tx_open;
  logic [15:0]      tx_crc;
  dfcc_pkg::phase_t rx_phase;
  logic [15:0]      rx_crc;
  logic [10:0]      rx_count;
  logic [9:0]       rx_len;
  logic [7:0]       rx_crc_hi;
  logic [9:0]       rx_limit;

  int cycle_cnt = 0;
  int accepted = 0;
  int total_items = 0;
  int squeeze_at = -1;
  int pause_at = -1;
  int tx_gap = 0;
  int rx_stall = 0;
  int words_checked = 0;
  int faults = 0;
  int status_tally [4] = '{0, 0, 0, 0};
  logic squeeze_go = 1'b0;
  logic squeeze_done = 1'b0;

  download_frame_crc_codec_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [7:0] data_byte, [17:8] deliver_limit
    .in_tuser   (in_tuser),   // [0] cmd
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [7:0] out_byte, [9:8] status
    .out_tuser  (out_tuser),  // [1:0] kind
    .out_tlast  (out_tlast)
  );

  always #(HALF_PERIOD) clk = ~clk;

  function automatic logic [15:0] crc16_update(input logic [15:0] c, input logic [7:0] d);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ d[i];
      c = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ dfcc_pkg::CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic codec_word_t mk_word(input dfcc_pkg::kind_t k, input logic [7:0] v,
                                          input dfcc_pkg::status_t s);
    codec_word_t w;
    w.kind = k;
    w.val = v;
    w.status = s;
    w.eor = 1'b0;
    return w;
  endfunction

  function automatic link_item_t mk_item(input logic cmd, input logic [7:0] d, input logic last,
                                         input logic [9:0] lim);
    link_item_t it;
    it.cmd = cmd;
    it.data = d;
    it.last = last;
    it.limit = lim;
    return it;
  endfunction

  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) begin
      return 0;
    end else if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  task automatic codec_predict(input link_item_t it);
    codec_word_t w[$];
    logic        done;
    done = 1'b0;
    if (it.cmd == CMD_SEND) begin
      if (!tx_open) begin
        tx_crc = dfcc_pkg::CRC_INIT;
        tx_open = 1'b1;
        w.push_back(mk_word(dfcc_pkg::KIND_LINE, dfcc_pkg::SEND_DIR, dfcc_pkg::ST_OK));
      end
      tx_crc = crc16_update(tx_crc, it.data);
      w.push_back(mk_word(dfcc_pkg::KIND_LINE, it.data, dfcc_pkg::ST_OK));
      if (it.last) begin
        w.push_back(mk_word(dfcc_pkg::KIND_LINE, tx_crc[15:8], dfcc_pkg::ST_OK));
        w.push_back(mk_word(dfcc_pkg::KIND_LINE, tx_crc[7:0], dfcc_pkg::ST_OK));
        tx_crc = dfcc_pkg::CRC_INIT;
        tx_open = 1'b0;
      end
    end else begin
      case (rx_phase)
        dfcc_pkg::PH_IDLE: begin
          rx_limit = it.limit;
          rx_crc = dfcc_pkg::CRC_INIT;
          rx_count = '0;
          rx_len = '0;
          rx_crc_hi = '0;
          if (it.data != dfcc_pkg::RECV_DIR) begin
            w.push_back(mk_word(dfcc_pkg::KIND_STATUS, 8'h00, dfcc_pkg::ST_BAD_DIR));
            rx_phase = it.last ? dfcc_pkg::PH_IDLE : dfcc_pkg::PH_DRAIN;
            done = 1'b1;
          end else begin
            rx_phase = dfcc_pkg::PH_LEN_HI;
          end
        end
        dfcc_pkg::PH_LEN_HI: begin
          rx_crc = crc16_update(rx_crc, it.data);
          rx_len = {it.data[1:0] & dfcc_pkg::LEN_HI_MASK, 8'h00};
          rx_phase = dfcc_pkg::PH_LEN_LO;
        end
        dfcc_pkg::PH_LEN_LO: begin
          rx_crc = crc16_update(rx_crc, it.data);
          rx_len = rx_len | {2'b00, it.data};
          rx_phase = (rx_len != '0) ? dfcc_pkg::PH_PAYLOAD : dfcc_pkg::PH_CRC_HI;
        end
        dfcc_pkg::PH_PAYLOAD: begin
          rx_crc = crc16_update(rx_crc, it.data);
          if (rx_count < {1'b0, rx_limit}) begin
            w.push_back(mk_word(dfcc_pkg::KIND_PAYLOAD, it.data, dfcc_pkg::ST_OK));
          end
          rx_count = rx_count + 11'd1;
          if (rx_count >= {1'b0, rx_len}) begin
            rx_phase = dfcc_pkg::PH_CRC_HI;
          end
        end
        dfcc_pkg::PH_CRC_HI: begin
          rx_crc_hi = it.data;
          rx_phase = dfcc_pkg::PH_CRC_LO;
        end
        dfcc_pkg::PH_CRC_LO: begin
          w.push_back(mk_word(dfcc_pkg::KIND_STATUS, 8'h00,
                              ({rx_crc_hi, it.data} == rx_crc) ? dfcc_pkg::ST_OK
                                                                : dfcc_pkg::ST_CRC_ERR));
          rx_phase = it.last ? dfcc_pkg::PH_IDLE : dfcc_pkg::PH_DRAIN;
          done = 1'b1;
        end
        default: begin
          if (it.last) begin
            rx_phase = dfcc_pkg::PH_IDLE;
          end
          done = 1'b1;
        end
      endcase
      if (!done && it.last) begin
        w.push_back(mk_word(dfcc_pkg::KIND_STATUS, 8'h00, dfcc_pkg::ST_TRUNCATED));
        rx_phase = dfcc_pkg::PH_IDLE;
      end
    end
    if (w.size() > 0) begin
      w[w.size() - 1].eor = 1'b1;
    end
    foreach (w[i]) begin
      if (w[i].kind == dfcc_pkg::KIND_STATUS) begin
        status_tally[w[i].status]++;
      end
      awaited_q.push_back(w[i]);
    end
  endtask

  task automatic stage_send(input int n);
    for (int i = 0; i < n; i++) begin
      tx_stage.push_back(mk_item(CMD_SEND, 8'($urandom), i == n - 1, 10'($urandom)));
    end
  endtask

  // cut: last kept byte index for FR_CUT, extra byte count for FR_TRAIL and FR_BAD_DIR
  task automatic stage_recv(input int len, input logic [9:0] lim, input frame_flaw_t flaw,
                            input int cut);
    logic [7:0]  fb[$];
    logic [15:0] crc;
    logic [7:0]  b;
    logic [5:0]  pad;
    logic [9:0]  len_v;
    int          n;
    len_v = 10'(len);
    if (flaw == FR_BAD_DIR) begin
      b = 8'($urandom);
      while (b == dfcc_pkg::RECV_DIR) begin
        b = 8'($urandom);
      end
      fb.push_back(b);
      repeat (cut) fb.push_back(8'($urandom));
    end else begin
      fb.push_back(dfcc_pkg::RECV_DIR);
      pad = 6'($urandom);
      b = {pad, len_v[9:8]};
      crc = crc16_update(dfcc_pkg::CRC_INIT, b);
      fb.push_back(b);
      crc = crc16_update(crc, len_v[7:0]);
      fb.push_back(len_v[7:0]);
      for (int i = 0; i < len; i++) begin
        b = 8'($urandom);
        crc = crc16_update(crc, b);
        fb.push_back(b);
      end
      if (flaw == FR_BAD_CRC) begin
        crc = crc ^ 16'($urandom_range(1, 65535));
      end
      fb.push_back(crc[15:8]);
      fb.push_back(crc[7:0]);
      if (flaw == FR_TRAIL) begin
        repeat (cut) fb.push_back(8'($urandom));
      end
      if (flaw == FR_CUT) begin
        while (fb.size() > cut + 1) begin
          void'(fb.pop_back());
        end
      end
    end
    n = fb.size();
    for (int i = 0; i < n; i++) begin
      rx_stage.push_back(mk_item(CMD_RECV, fb[i], i == n - 1, (i == 0) ? lim : 10'($urandom)));
    end
  endtask

  task automatic merge_stages();
    while (tx_stage.size() + rx_stage.size() > 0) begin
      if (rx_stage.size() == 0 || (tx_stage.size() > 0 && $urandom_range(0, 2) == 0)) begin
        feed_q.push_back(tx_stage.pop_front());
      end else begin
        feed_q.push_back(rx_stage.pop_front());
      end
    end
  endtask

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("download_frame_crc_codec_top verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tuser <= 1'b0;
      in_tlast <= 1'b0;
      tx_gap <= 0;
      squeeze_go <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        codec_predict(cur_item);
        accepted = accepted + 1;
        if (accepted == squeeze_at) begin
          squeeze_go <= 1'b1;
        end
      end
      if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
        in_tvalid <= 1'b0;
      end else if (feed_q.size() > 0 && (accepted != pause_at || awaited_q.size() == 0)) begin
        cur_item = feed_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {6'd0, cur_item.limit, cur_item.data};
        in_tuser <= cur_item.cmd;
        in_tlast <= cur_item.last;
        tx_gap <= pick_gap((cycle_cnt % 2048) < 400);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : rx_side
    int g;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_stall <= 0;
      squeeze_done <= 1'b0;
    end else if (rx_stall > 0) begin
      out_tready <= 1'b0;
      rx_stall <= rx_stall - 1;
    end else if (squeeze_go && !squeeze_done) begin
      out_tready <= 1'b0;
      rx_stall <= SQUEEZE_CYCLES - 1;
      squeeze_done <= 1'b1;
    end else begin
      g = pick_gap((cycle_cnt % 2048) < 400);
      if (g == 0) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        rx_stall <= g - 1;
      end
    end
  end

  always @(posedge clk) begin : out_check
    codec_word_t w;
    if (rst_n && out_tvalid && out_tready) begin
      words_checked++;
      if (awaited_q.size() == 0) begin
        faults++;
        if (faults <= REPORT_CAP) begin
          $display("%0t: extra word: expected none, got k %0d b %02h s %0d l %0b",
                   $time, out_tuser, out_tdata[7:0], out_tdata[9:8], out_tlast);
        end
      end else begin
        w = awaited_q.pop_front();
        if (out_tuser !== w.kind || out_tdata[7:0] !== w.val || out_tdata[9:8] !== w.status ||
            out_tlast !== w.eor) begin
          faults++;
          if (faults <= REPORT_CAP) begin
            $display("%0t: mismatch: expected k %0d b %02h s %0d l %0b, got k %0d b %02h s %0d l %0b",
                     $time, w.kind, w.val, w.status, w.eor,
                     out_tuser, out_tdata[7:0], out_tdata[9:8], out_tlast);
          end
        end
      end
    end
  end

  initial begin
    int          directed_n;
    int          len;
    int          cut;
    int          r;
    logic [9:0]  lim;
    frame_flaw_t flaw;

    tx_open = 1'b0;
    tx_crc = dfcc_pkg::CRC_INIT;
    rx_phase = dfcc_pkg::PH_IDLE;
    rx_crc = dfcc_pkg::CRC_INIT;
    rx_count = '0;
    rx_len = '0;
    rx_crc_hi = '0;
    rx_limit = '0;

    feed_q.push_back(mk_item(CMD_SEND, 8'h00, 1'b1, 10'd0));
    feed_q.push_back(mk_item(CMD_SEND, 8'hFF, 1'b0, 10'h3FF));
    feed_q.push_back(mk_item(CMD_RECV, 8'h00, 1'b1, 10'd0));
    feed_q.push_back(mk_item(CMD_SEND, 8'h80, 1'b1, 10'd0));
    stage_recv(0, 10'h3FF, FR_TRAIL, 1);
    stage_recv(2, 10'd1, FR_BAD_CRC, 0);
    stage_recv(0, 10'd0, FR_BAD_DIR, 2);
    stage_recv(1, 10'd5, FR_CUT, 3);
    stage_recv(4, 10'd4, FR_CUT, 0);
    merge_stages();
    directed_n = feed_q.size();

    while (feed_q.size() < directed_n + RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 25) begin
        stage_send($urandom_range(1, 6));
      end
      r = $urandom_range(0, 99);
      if (r < 8) begin
        rx_stage.push_back(mk_item(CMD_RECV, 8'($urandom), $urandom_range(0, 3) != 0,
                                   10'($urandom)));
      end else begin
        flaw = (r < 58) ? FR_CLEAN : (r < 70) ? FR_BAD_CRC : (r < 83) ? FR_CUT :
               (r < 92) ? FR_TRAIL : FR_BAD_DIR;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        cut = $urandom_range(1, 3);
        if (flaw == FR_CUT) begin
          if ($urandom_range(0, 2) == 0) begin
            len = $urandom_range(256, 1023);
            cut = $urandom_range(3, 14);
          end else begin
            cut = $urandom_range(0, len + 3);
          end
        end
        if (flaw == FR_BAD_DIR) begin
          cut = $urandom_range(0, 3);
        end
        lim = $urandom_range(0, 1) ? 10'($urandom_range(0, 1023))
                                   : 10'($urandom_range(0, (len < 1000) ? len + 1 : 1023));
        stage_recv(len, lim, flaw, cut);
      end
      merge_stages();
    end
    total_items = feed_q.size();
    squeeze_at = directed_n + 40;
    pause_at = directed_n + 150;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted < total_items) @(posedge clk);
    while (awaited_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d input words and %0d output words, send and receive interleaved.",
             total_items, words_checked);
    $display("Receive outcomes: %0d ok, %0d bad direction, %0d CRC mismatch, %0d truncated.",
             status_tally[dfcc_pkg::ST_OK], status_tally[dfcc_pkg::ST_BAD_DIR],
             status_tally[dfcc_pkg::ST_CRC_ERR], status_tally[dfcc_pkg::ST_TRUNCATED]);
    if (faults == 0 && awaited_q.size() == 0) begin
      $display("download_frame_crc_codec_top verification clean");
    end else begin
      $display("download_frame_crc_codec_top verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/dfcc_pkg.sv
rtl/dfcc_front.sv
rtl/dfcc_queue.sv
rtl/dfcc_back.sv
rtl/download_frame_crc_codec_top.sv
test/tb_download_frame_crc_codec_top.sv
